FILE: hw/rtl/cbim_pkg.sv
// Shared definitions for the cartridge bank and IRQ mapper.
// Holds register codes, command codes, stream widths and word layouts.
// No dependencies.
package cbim_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Kinds of input word, carried on in_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Register numbers of a write word.
  localparam logic [3:0] REG_PRG      = 4'h8;
  localparam logic [3:0] REG_MIRROR   = 4'h9;
  localparam logic [3:0] REG_IRQ_CTRL = 4'hA;
  localparam logic [3:0] REG_LATCH_LO = 4'hB;
  localparam logic [3:0] REG_LATCH_HI = 4'hC;
  localparam logic [3:0] REG_EEPROM   = 4'hD;

  // Bits of the byte written to the EEPROM register.
  localparam int EE_CLK_BIT  = 5;
  localparam int EE_DATA_BIT = 6;
  localparam int EE_RDEN_BIT = 7;

  // Bit position of the strobe in the result word.
  localparam int OUT_STROBE_BIT = 15;

  // Fields of one input word (packed, last member in the lowest bits).
  typedef struct packed {
    logic [2:0]  query_slot;
    logic [15:0] cycles;
    logic [7:0]  write_data;
    logic [3:0]  reg_addr;
  } in_word_t;

  // Fields of one result word.
  typedef struct packed {
    logic       eeprom_data;
    logic       eeprom_clock;
    logic       eeprom_strobe;
    logic [7:0] char_bank;
    logic [1:0] mirror_mode;
    logic [3:0] program_bank;
    logic       irq_line;
  } out_word_t;

endpackage

FILE: hw/rtl/cartridge_bank_irq_mapper.sv
// Top level of the cartridge bank and IRQ mapper register block.
// Depends on cbim_pkg for register codes and the word layouts.
//
// Usage: every input word is either a register write (in_tuser low) or a
// timer tick (in_tuser high). Writes to registers 0-7 set the 8 character
// banks, 8 the program bank, 9 the mirroring mode, B and C the IRQ reload
// latch, A acknowledges the IRQ and reloads the counter, and D drives the
// serial EEPROM pins. A tick counts the 16-bit IRQ counter down by its
// cycles field while enabled, raising the IRQ as it reaches or passes zero.
//
// Every accepted input word yields exactly one result word that reports the
// IRQ line, the program bank, the mirroring mode, the character bank of the
// queried slot and the EEPROM pins, all as they stand after the word.
//
// The state update and the result are computed in the accept cycle and the
// result word is held in the output register. Throughput is one word per
// cycle, set by the single output register, which is reloaded in the same
// cycle its word is taken. When the receiver stalls, the output register
// holds its word and in_tready drops until it is taken.
//
// Reset (rst_n low, synchronous) clears all banks, the IRQ logic and the
// output valid flag, and leaves the EEPROM clock low and its data pin high.
module cartridge_bank_irq_mapper
  import cbim_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] reg_addr, [11:4] write_data, [27:12] cycles, [30:28] query_slot
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] irq_line, [4:1] program_bank, [6:5] mirror_mode, [14:7] char_bank,
  // [15] eeprom_strobe, [16] eeprom_clock, [17] eeprom_data
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  in_word_t  in_word;
  out_word_t res;
  logic      accept;
  logic      is_write;
  logic      is_tick;

  logic [7:0]  char_banks_r [8];
  logic [7:0]  char_banks_nxt [8];
  logic [3:0]  prog_bank_r, prog_bank_nxt;
  logic [1:0]  mirror_r, mirror_nxt;
  logic [15:0] irq_reload_r, irq_reload_nxt;
  logic [15:0] irq_count_r, irq_count_nxt;
  logic        irq_enable_r, irq_enable_nxt;
  logic        irq_level_r, irq_level_nxt;
  logic        ee_clk_r, ee_clk_nxt;
  logic        ee_data_r, ee_data_nxt;
  logic        strobe;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign in_word   = in_word_t'(in_tdata[$bits(in_word_t)-1:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_write  = accept && (in_tuser == CMD_WRITE);
  assign is_tick   = accept && (in_tuser == CMD_TICK);

  // Register decode and IRQ counter, all in one pass.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      char_banks_nxt[i] = char_banks_r[i];
    end
    prog_bank_nxt  = prog_bank_r;
    mirror_nxt     = mirror_r;
    irq_reload_nxt = irq_reload_r;
    irq_count_nxt  = irq_count_r;
    irq_enable_nxt = irq_enable_r;
    irq_level_nxt  = irq_level_r;
    ee_clk_nxt     = ee_clk_r;
    ee_data_nxt    = ee_data_r;
    strobe         = 1'b0;

    if (is_write) begin
      if (!in_word.reg_addr[3]) begin
        char_banks_nxt[in_word.reg_addr[2:0]] = in_word.write_data;
      end else begin
        case (in_word.reg_addr)
          REG_PRG:      prog_bank_nxt = in_word.write_data[3:0];
          REG_MIRROR:   mirror_nxt = in_word.write_data[1:0];
          REG_IRQ_CTRL: begin
            // Acknowledge, reload, and fire at once when enabled with a zero reload value.
            irq_count_nxt  = irq_reload_r;
            irq_enable_nxt = in_word.write_data[0];
            irq_level_nxt  = in_word.write_data[0] && (irq_reload_r == 16'd0);
          end
          REG_LATCH_LO: irq_reload_nxt = {irq_reload_r[15:8], in_word.write_data};
          REG_LATCH_HI: irq_reload_nxt = {in_word.write_data, irq_reload_r[7:0]};
          REG_EEPROM:   begin
            ee_clk_nxt  = in_word.write_data[EE_CLK_BIT];
            // With read enable set the data pin is released and reads high.
            ee_data_nxt = in_word.write_data[EE_RDEN_BIT] ||
                          in_word.write_data[EE_DATA_BIT];
            strobe      = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (is_tick && irq_enable_r) begin
      if (irq_count_r <= in_word.cycles) begin
        irq_level_nxt = 1'b1;
      end
      irq_count_nxt = irq_count_r - in_word.cycles;
    end
  end

  always_comb begin
    res.irq_line      = irq_level_nxt;
    res.program_bank  = prog_bank_nxt;
    res.mirror_mode   = mirror_nxt;
    res.char_bank     = char_banks_nxt[in_word.query_slot];
    res.eeprom_strobe = strobe;
    res.eeprom_clock  = ee_clk_nxt;
    res.eeprom_data   = ee_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        char_banks_r[i] <= 8'd0;
      end
      prog_bank_r  <= 4'd0;
      mirror_r     <= 2'd0;
      irq_reload_r <= 16'd0;
      irq_count_r  <= 16'd0;
      irq_enable_r <= 1'b0;
      irq_level_r  <= 1'b0;
      ee_clk_r     <= 1'b0;
      ee_data_r    <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        char_banks_r[i] <= char_banks_nxt[i];
      end
      prog_bank_r  <= prog_bank_nxt;
      mirror_r     <= mirror_nxt;
      irq_reload_r <= irq_reload_nxt;
      irq_count_r  <= irq_count_nxt;
      irq_enable_r <= irq_enable_nxt;
      irq_level_r  <= irq_level_nxt;
      ee_clk_r     <= ee_clk_nxt;
      ee_data_r    <= ee_data_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result word itself needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {{(OUT_TDATA_W-$bits(out_word_t)){1'b0}}, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted word always leaves a result waiting in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  // The IRQ can only rise while the timer is enabled.
  a_irq_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_level_r) |-> irq_enable_r)
    else $error("IRQ raised while timer disabled");

  // The strobe is only reported for a write to the EEPROM register.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !(in_tuser == CMD_WRITE && in_word.reg_addr == REG_EEPROM))
      |=> !out_data_r[OUT_STROBE_BIT])
    else $error("EEPROM strobe without EEPROM write");

  // A tick while disabled leaves the counter untouched.
  a_disabled_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && !irq_enable_r) |=> $stable(irq_count_r))
    else $error("counter moved while disabled");

endmodule

FILE: test/cartridge_bank_irq_mapper_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cartridge bank and IRQ mapper register block.
// Depends on cbim_pkg and the cartridge_bank_irq_mapper top level, nothing else.
module cartridge_bank_irq_mapper_tb
  import cbim_pkg::*;
();

  // Register numbers that the package leaves unnamed.
  localparam logic [3:0] REG_CHR_FIRST = 4'h0;
  localparam logic [3:0] REG_CHR_LAST  = 4'h7;
  localparam logic [3:0] REG_SPARE_E   = 4'hE;
  localparam logic [3:0] REG_SPARE_F   = 4'hF;

  localparam int RANDOM_CHUNKS    = 10;
  localparam int CHUNK_WORDS      = 100;
  localparam int PRESSURE_WORDS   = 40;
  localparam int RX_HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES     = 8;
  localparam int MAX_PRINTED      = 40;
  // Worst case is roughly 1100 words with the longest idle gaps on both sides;
  // the limit leaves close to a factor of ten on top of that.
  localparam longint RUN_LIMIT_NS = 3_000_000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = CMD_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Idle controls. The sender reads tx_idle in its own process; the result
  // sink reads rx_idle and rx_hold, so those two are driven nonblocking.
  bit   tx_idle = 1'b0;
  bit   rx_idle = 1'b0;
  bit   rx_hold = 1'b0;
  event rx_hold_go;

  // Scoreboard bookkeeping.
  out_word_t mapper_expect_q[$];
  int unsigned mismatches      = 0;
  int unsigned n_checked       = 0;
  int unsigned n_writes        = 0;
  int unsigned n_ticks         = 0;
  int unsigned n_irq_high      = 0;
  int unsigned n_strobes       = 0;
  int unsigned in_stall_cycles = 0;

  // Predicted register state of the mapper, updated once per accepted word.
  logic [7:0]  chr_bank_m [8] = '{default: 8'h00};
  logic [3:0]  prg_bank_m     = 4'h0;
  logic [1:0]  mirror_m       = 2'b00;
  logic [15:0] irq_latch_m    = 16'h0000;
  logic [15:0] irq_cnt_m      = 16'h0000;
  logic        irq_en_m       = 1'b0;
  logic        irq_line_m     = 1'b0;
  logic        ee_clk_m       = 1'b0;
  logic        ee_data_m      = 1'b1;

  cartridge_bank_irq_mapper u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one accepted word to the predicted state and returns the result
  // word the block should produce for it. Fields a word does not use are
  // simply never looked at.
  function automatic out_word_t mapper_predict(input logic cmd, input in_word_t w);
    out_word_t r;
    logic      strobe;
    strobe = 1'b0;
    if (cmd == CMD_WRITE) begin
      if (w.reg_addr <= REG_CHR_LAST) begin
        chr_bank_m[w.reg_addr[2:0]] = w.write_data;
      end else begin
        case (w.reg_addr)
          REG_PRG:      prg_bank_m = w.write_data[3:0];
          REG_MIRROR:   mirror_m   = w.write_data[1:0];
          REG_IRQ_CTRL: begin
            // Acknowledge, reload, then re-arm; an enabled counter that
            // reloads to zero fires right away.
            irq_cnt_m  = irq_latch_m;
            irq_en_m   = w.write_data[0];
            irq_line_m = irq_en_m && (irq_cnt_m == 16'h0000);
          end
          REG_LATCH_LO: irq_latch_m[7:0]  = w.write_data;
          REG_LATCH_HI: irq_latch_m[15:8] = w.write_data;
          REG_EEPROM: begin
            ee_clk_m  = w.write_data[EE_CLK_BIT];
            ee_data_m = w.write_data[EE_RDEN_BIT] | w.write_data[EE_DATA_BIT];
            strobe    = 1'b1;
          end
          default: ;  // Spare registers E and F do nothing.
        endcase
      end
    end else if (irq_en_m) begin
      // The counter fires when it reaches or passes zero, then wraps.
      if (irq_cnt_m <= w.cycles) irq_line_m = 1'b1;
      irq_cnt_m = irq_cnt_m - w.cycles;
    end
    r.irq_line      = irq_line_m;
    r.program_bank  = prg_bank_m;
    r.mirror_mode   = mirror_m;
    r.char_bank     = chr_bank_m[w.query_slot];
    r.eeprom_strobe = strobe;
    r.eeprom_clock  = ee_clk_m;
    r.eeprom_data   = ee_data_m;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t ns: result %0d: %s got 0x%0h, expected 0x%0h",
               $time, n_checked, what, got, want);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Scoreboard. Input and output handshakes are handled in one process, the
  // input side first, so an expectation always exists before its result is
  // compared, whatever the latency of the block. All signals are read right
  // after the edge, before any nonblocking update of that edge lands.
  always @(posedge clk) begin : scoreboard
    in_word_t  w;
    out_word_t got;
    out_word_t want;
    if (rst_n) begin
      if (in_tvalid && !in_tready) in_stall_cycles++;
      if (in_tvalid && in_tready) begin
        w = in_tdata[$bits(in_word_t)-1:0];
        mapper_expect_q.push_back(mapper_predict(in_tuser, w));
        if (in_tuser == CMD_TICK) n_ticks++;
        else n_writes++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(out_word_t)-1:0];
        if (mapper_expect_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding", got, 0);
        end else begin
          want = mapper_expect_q.pop_front();
          n_checked++;
          if (want.irq_line) n_irq_high++;
          if (want.eeprom_strobe) n_strobes++;
          check_field("irq_line", got.irq_line, want.irq_line);
          check_field("program_bank", got.program_bank, want.program_bank);
          check_field("mirror_mode", got.mirror_mode, want.mirror_mode);
          check_field("char_bank", got.char_bank, want.char_bank);
          check_field("eeprom_strobe", got.eeprom_strobe, want.eeprom_strobe);
          check_field("eeprom_clock", got.eeprom_clock, want.eeprom_clock);
          check_field("eeprom_data", got.eeprom_data, want.eeprom_data);
        end
      end
    end
  end

  // Result sink. After each accepted result it draws a random wait when
  // idling is on; a long hold overrides everything.
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) wait_left = rx_idle ? $urandom_range(0, 15) : 0;
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left = wait_left - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold, counted here so the sender keeps offering words and
  // the block has to push back on its input.
  initial begin : rx_hold_timer
    forever begin
      @(rx_hold_go);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // Sends one word: an optional gap with tvalid low, then tvalid high until
  // the edge at which the block takes the word. A back-to-back word keeps
  // tvalid high without lowering it in between.
  task automatic send_word(input logic cmd, input logic [3:0] reg_addr,
                           input logic [7:0] data, input logic [15:0] cycles,
                           input logic [2:0] slot);
    in_word_t w;
    int       gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.reg_addr   = reg_addr;
    w.write_data = data;
    w.cycles     = cycles;
    w.query_slot = slot;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - $bits(in_word_t)){1'b0}}, w};
    do @(posedge clk); while (!in_tready);
  endtask

  // Register write; the unused cycle count is random.
  task automatic send_write(input logic [3:0] reg_addr, input logic [7:0] data,
                            input logic [2:0] slot);
    send_word(CMD_WRITE, reg_addr, data, 16'($urandom), slot);
  endtask

  // Timer tick; the unused register number and byte are random.
  task automatic send_tick(input logic [15:0] cycles, input logic [2:0] slot);
    send_word(CMD_TICK, 4'($urandom), 8'($urandom), cycles, slot);
  endtask

  // Every character bank with edge values, read back through its own slot,
  // then program bank and mirroring with all bits set (upper bits must be
  // dropped) and the two spare registers, which must leave everything alone.
  task automatic test_bank_registers();
    logic [7:0] pattern [8];
    pattern = '{8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h00};
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    for (int i = REG_CHR_FIRST; i <= REG_CHR_LAST; i++)
      send_write(4'(i), pattern[i], 3'(i));
    send_write(REG_PRG, 8'hFF, 3'd0);
    send_write(REG_MIRROR, 8'hFF, 3'd7);
    send_write(REG_SPARE_E, 8'hFF, 3'd3);
    send_write(REG_SPARE_F, 8'hFF, 3'd4);
  endtask

  // EEPROM pins: clock up with data driven low, read enable releasing the
  // data pin although its own bit is clear, then data driven high.
  task automatic test_eeprom_pins();
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    send_write(REG_EEPROM, 8'h20, 3'd1);
    send_write(REG_EEPROM, 8'hA0, 3'd2);
    send_write(REG_EEPROM, 8'h40, 3'd5);
  endtask

  // IRQ timer corners: arming with a zero latch fires at once, an
  // acknowledge with the enable bit clear drops the line and stops the
  // counter, a zero-cycle tick, an exact hit, a wrap past zero, and the
  // full 16-bit latch run down by the largest tick.
  task automatic test_irq_timer();
    tx_idle = 1'b0;
    rx_idle <= 1'b1;
    send_write(REG_IRQ_CTRL, 8'h01, 3'd0);
    send_write(REG_IRQ_CTRL, 8'hFE, 3'd1);
    send_tick(16'hFFFF, 3'd2);
    send_write(REG_LATCH_LO, 8'h03, 3'd3);
    send_write(REG_LATCH_HI, 8'h00, 3'd4);
    send_write(REG_IRQ_CTRL, 8'h01, 3'd5);
    send_tick(16'h0000, 3'd6);
    send_tick(16'h0002, 3'd7);
    send_tick(16'h0001, 3'd0);
    send_tick(16'hFFFF, 3'd1);
    send_write(REG_LATCH_HI, 8'hFF, 3'd2);
    send_write(REG_LATCH_LO, 8'hFF, 3'd3);
    send_write(REG_IRQ_CTRL, 8'hFF, 3'd4);
    send_tick(16'hFFFF, 3'd5);
  endtask

  // One random word of the mixed traffic below; returns how many words it
  // sent. Arming sequences keep reload values small so that the counter
  // actually fires, ticks lean toward small counts near the boundary.
  task automatic send_random_step(output int sent);
    logic [7:0]  ctrl;
    logic [15:0] cyc;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      send_write(REG_LATCH_LO,
                 ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 31)) : 8'($urandom),
                 3'($urandom));
      send_write(REG_LATCH_HI, ($urandom_range(0, 9) < 8) ? 8'h00 : 8'($urandom),
                 3'($urandom));
      ctrl = 8'($urandom);
      if ($urandom_range(0, 9) < 8) ctrl[0] = 1'b1;
      send_write(REG_IRQ_CTRL, ctrl, 3'($urandom));
      sent = 3;
    end else if (sel < 60) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: cyc = 16'($urandom_range(0, 3));
        5, 6, 7:       cyc = 16'($urandom_range(0, 40));
        default:       cyc = 16'($urandom);
      endcase
      send_tick(cyc, 3'($urandom));
      sent = 1;
    end else if (sel < 85) begin
      case ($urandom_range(0, 5))
        0:       send_write(REG_PRG, 8'($urandom), 3'($urandom));
        1:       send_write(REG_MIRROR, 8'($urandom), 3'($urandom));
        2:       send_write(REG_EEPROM, 8'($urandom), 3'($urandom));
        3:       send_write($urandom_range(0, 1) ? REG_SPARE_E : REG_SPARE_F,
                            8'($urandom), 3'($urandom));
        default: send_write(4'($urandom_range(REG_CHR_FIRST, REG_CHR_LAST)),
                            8'($urandom), 3'($urandom));
      endcase
      sent = 1;
    end else begin
      // Noise: any kind, any register, any field values.
      send_word(1'($urandom), 4'($urandom), 8'($urandom), 16'($urandom),
                3'($urandom));
      sent = 1;
    end
  endtask

  // The receiver stops for a long stretch while words keep coming without
  // gaps, so the output register fills and in_tready has to drop.
  task automatic test_backpressure();
    int sent;
    int total;
    total = 0;
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    -> rx_hold_go;
    while (total < PRESSURE_WORDS) begin
      send_random_step(sent);
      total += sent;
    end
  endtask

  // Bulk random traffic in chunks; the first chunk runs flat out on both
  // sides, the others switch sender and receiver idling at random.
  task automatic test_random_traffic();
    int sent;
    int total;
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      tx_idle = (c != 0) && ($urandom_range(0, 2) != 0);
      rx_idle <= (c != 0) && ($urandom_range(0, 2) != 0);
      total = 0;
      while (total < CHUNK_WORDS) begin
        send_random_step(sent);
        total += sent;
      end
    end
  endtask

  initial begin : main_sequence
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bank_registers();
    test_eeprom_pins();
    test_irq_timer();
    test_backpressure();
    test_random_traffic();

    in_tvalid <= 1'b0;
    while (mapper_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d register writes and %0d timer ticks; %0d results checked.",
             n_writes, n_ticks, n_checked);
    $display("IRQ high in %0d results, EEPROM strobe in %0d, input held off %0d cycles.",
             n_irq_high, n_strobes, in_stall_cycles);
    if (mismatches == 0) begin
      $display("** cartridge_bank_irq_mapper: PASSED **");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("** cartridge_bank_irq_mapper: FAILED **");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results outstanding.", mapper_expect_q.size());
    $display("** cartridge_bank_irq_mapper: FAILED **");
    $finish;
  end

endmodule
